// File: rtl/core/llrs_pkg.sv
// Shared types and constants for the life-like automaton row step block.
`timescale 1ns / 1ps

package llrs_pkg;

	localparam int unsigned MaxWidth  = 1024;
	localparam int unsigned MaskW     = 10;
	localparam int unsigned WidthW    = 11;
	localparam int unsigned ColW      = 2;
	localparam int unsigned SumW      = 4;
	localparam int unsigned RegIndexW = 2;

	localparam logic [MaskW-1:0]  AliveMaskReset = MaskW'(24);
	localparam logic [MaskW-1:0]  DeadMaskReset  = MaskW'(8);
	localparam logic [WidthW-1:0] RowWidthReset  = WidthW'(MaxWidth);
	localparam logic [WidthW-1:0] CountMax       = {WidthW{1'b1}};

	// Configuration register indexes
	typedef enum logic [RegIndexW-1:0] {
		REG_ALIVE_MASK = 2'd0,
		REG_DEAD_MASK  = 2'd1,
		REG_ROW_WIDTH  = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [MaskW-1:0]  alive_mask;
		logic [MaskW-1:0]  dead_mask;
		logic [WidthW-1:0] row_width;
	} cfg_t;

	typedef struct packed {
		logic              has_result;
		logic              next_cell;
		logic [WidthW-1:0] live_total;
		logic              row_end;
	} result_t;

endpackage

// File: rtl/core/llrs_window.sv
// Sliding 3x3 window, rule lookup and per-row counters.
`timescale 1ns / 1ps

module llrs_window (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 above,
	input  logic                 centre,
	input  logic                 below,
	input  llrs_pkg::cfg_t       cfg,
	output llrs_pkg::result_t    res
);

	logic [llrs_pkg::ColW-1:0]   older_sum_q;
	logic [llrs_pkg::ColW-1:0]   newer_sum_q;
	logic                        prev_centre_q;
	logic [llrs_pkg::WidthW-1:0] col_index_q;
	logic [llrs_pkg::WidthW-1:0] live_count_q;

	logic [llrs_pkg::ColW-1:0]   col_sum;
	logic [llrs_pkg::SumW-1:0]   win_sum;
	logic [llrs_pkg::MaskW-1:0]  mask;
	logic [llrs_pkg::WidthW-1:0] eff_width;
	logic                        filling;
	logic                        next_bit;
	logic                        last;
	logic [llrs_pkg::WidthW-1:0] count_next;

	// Clamp the row width into 1..MaxWidth
	always_comb begin
		if (cfg.row_width == '0) begin
			eff_width = llrs_pkg::WidthW'(1);
		end else if (cfg.row_width > llrs_pkg::WidthW'(llrs_pkg::MaxWidth)) begin
			eff_width = llrs_pkg::WidthW'(llrs_pkg::MaxWidth);
		end else begin
			eff_width = cfg.row_width;
		end
	end

	// Form the column and window sums and look up the rule
	always_comb begin
		col_sum  = llrs_pkg::ColW'({1'b0, above}) + llrs_pkg::ColW'({1'b0, centre})
			+ llrs_pkg::ColW'({1'b0, below});
		win_sum  = llrs_pkg::SumW'(older_sum_q) + llrs_pkg::SumW'(newer_sum_q)
			+ llrs_pkg::SumW'(col_sum);
		mask     = prev_centre_q ? cfg.alive_mask : cfg.dead_mask;
		next_bit = mask[win_sum];
		filling  = (col_index_q < llrs_pkg::WidthW'(2));
		last     = ({1'b0, col_index_q} >= ({1'b0, eff_width} + 12'd1));
		if (next_bit && (live_count_q != llrs_pkg::CountMax)) begin
			count_next = live_count_q + llrs_pkg::WidthW'(1);
		end else begin
			count_next = live_count_q;
		end
	end

	assign res.has_result = !filling;
	assign res.next_cell  = next_bit;
	assign res.live_total = count_next;
	assign res.row_end    = last;

	// Advance the window on each processed column, clear it at row end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_sum_q   <= '0;
			newer_sum_q   <= '0;
			prev_centre_q <= 1'b0;
			col_index_q   <= '0;
			live_count_q  <= '0;
		end else if (step) begin
			if (!filling && last) begin
				older_sum_q   <= '0;
				newer_sum_q   <= '0;
				prev_centre_q <= 1'b0;
				col_index_q   <= '0;
				live_count_q  <= '0;
			end else begin
				older_sum_q   <= newer_sum_q;
				newer_sum_q   <= col_sum;
				prev_centre_q <= centre;
				col_index_q   <= col_index_q + llrs_pkg::WidthW'(1);
				if (!filling) begin
					live_count_q <= count_next;
				end
			end
		end
	end

endmodule

// File: rtl/core/life_like_automaton_row_step_top.sv
// A column beat is held in the input register, its result in the result register.
// Throughput: one column beat per cycle unless out_stall holds a result; the two
// registers each hold one beat, and the window state updates once per column.
// The first two columns of each row fill the window and give no result.
// Reset: masks return to 24 and 8, row width to 1024; window and counters clear.
`timescale 1ns / 1ps

module life_like_automaton_row_step_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [llrs_pkg::RegIndexW-1:0] wr_index,
	input  logic [llrs_pkg::WidthW-1:0]    wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           cell_above,
	input  logic                           cell_centre,
	input  logic                           cell_below,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           next_cell,
	output logic [llrs_pkg::WidthW-1:0]    live_total,
	output logic                           row_end
);

	llrs_pkg::cfg_t    cfg_q;
	llrs_pkg::result_t res;

	logic                        valid_s1;
	logic                        above_s1;
	logic                        centre_s1;
	logic                        below_s1;
	logic                        out_valid_q;
	logic                        next_cell_q;
	logic [llrs_pkg::WidthW-1:0] live_total_q;
	logic                        row_end_q;
	logic                        out_free;
	logic                        step;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alive_mask <= llrs_pkg::AliveMaskReset;
			cfg_q.dead_mask  <= llrs_pkg::DeadMaskReset;
			cfg_q.row_width  <= llrs_pkg::RowWidthReset;
		end else if (wr_en) begin
			unique case (llrs_pkg::reg_index_t'(wr_index))
				llrs_pkg::REG_ALIVE_MASK: cfg_q.alive_mask <= wr_data[llrs_pkg::MaskW-1:0];
				llrs_pkg::REG_DEAD_MASK:  cfg_q.dead_mask  <= wr_data[llrs_pkg::MaskW-1:0];
				llrs_pkg::REG_ROW_WIDTH:  cfg_q.row_width  <= wr_data;
				default: ;
			endcase
		end
	end

	// Handshake: the stage-1 beat leaves when it has no result or the output can take it
	assign out_free = !out_valid_q || !out_stall;
	assign step     = valid_s1 && (!res.has_result || out_free);
	assign in_stall = valid_s1 && !step;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			above_s1  <= cell_above;
			centre_s1 <= cell_centre;
			below_s1  <= cell_below;
		end
	end

	llrs_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.above  (above_s1),
		.centre (centre_s1),
		.below  (below_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// Result register: load a new beat, drop the old one once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && res.has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.has_result) begin
			next_cell_q  <= res.next_cell;
			live_total_q <= res.live_total;
			row_end_q    <= res.row_end;
		end
	end

	assign out_valid  = out_valid_q;
	assign next_cell  = next_cell_q;
	assign live_total = live_total_q;
	assign row_end    = row_end_q;

endmodule
